/* src/multi_channel_led_blinker_assert.svh */
// Assertion macros shared by the RTL.
// Compile with ASSERT_OFF defined to remove all checks.
`ifndef MULTI_CHANNEL_LED_BLINKER_ASSERT_SVH
`define MULTI_CHANNEL_LED_BLINKER_ASSERT_SVH

`ifndef ASSERT_OFF
// property that must hold at every clock edge outside reset
`define MCLB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mclb assertion failed");
// antecedent in this cycle implies consequent in the next one
`define MCLB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mclb assertion failed");
`else
`define MCLB_ASSERT(lbl, clk, rst_n, prop)
`define MCLB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* src/mclb_pkg.sv */
`default_nettype none

package mclb_pkg;

    // number of LED channels and width of the time values
    localparam int CHANNELS     = 4;
    localparam int TIME_BITS    = 16;
    localparam int ELAPSED_BITS = TIME_BITS + 1;
    // channels that appear in the 4-bit result fields
    localparam int OUT_CH       = (CHANNELS < 4) ? CHANNELS : 4;

    // command codes
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_OFF   = 3'd1;
    localparam logic [2:0] CMD_ON    = 3'd2;
    localparam logic [2:0] CMD_TOG   = 3'd3;
    localparam logic [2:0] CMD_BLINK = 3'd4;

    typedef logic [TIME_BITS-1:0]    t_time;
    typedef logic [ELAPSED_BITS-1:0] t_elapsed;

    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  channel;
        logic [15:0] on_time;
        logic [15:0] blink_period;
        logic [15:0] repeat_count;
    } t_req;

    typedef struct packed {
        logic [3:0] led_levels;
        logic [3:0] blink_active;
    } t_rsp;

endpackage

`default_nettype wire

/* src/multi_channel_led_blinker.sv */
// Four-channel LED blink controller. Each request is a tick or a command
// (off, on, toggle, start blink) aimed at one channel; every request yields
// exactly one response carrying all LED levels and blink-active flags after
// that request took effect. Requests pass an input register, then the
// per-channel counter/compare logic that updates the channel state and
// loads the response register, so one request is accepted every cycle while
// responses are taken, and each response is held in that register until taken. The input
// stage keeps accepting while a response waits, until both registers are full.
`default_nettype none

`include "multi_channel_led_blinker_assert.svh"

module multi_channel_led_blinker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire mclb_pkg::t_req i_req,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_ready,
    output mclb_pkg::t_rsp     o_rsp
);

    // input stage
    logic            r_in_valid;
    mclb_pkg::t_req  r_in;
    logic            w_adv;

    // per-channel state
    logic                      r_level   [mclb_pkg::CHANNELS];
    mclb_pkg::t_time           r_lit     [mclb_pkg::CHANNELS];
    mclb_pkg::t_time           r_cycle   [mclb_pkg::CHANNELS];
    mclb_pkg::t_time           r_rep     [mclb_pkg::CHANNELS];
    mclb_pkg::t_elapsed        r_elapsed [mclb_pkg::CHANNELS];
    logic                      n_level   [mclb_pkg::CHANNELS];
    mclb_pkg::t_time           n_lit     [mclb_pkg::CHANNELS];
    mclb_pkg::t_time           n_cycle   [mclb_pkg::CHANNELS];
    mclb_pkg::t_time           n_rep     [mclb_pkg::CHANNELS];
    mclb_pkg::t_elapsed        n_elapsed [mclb_pkg::CHANNELS];

    // tick helpers
    mclb_pkg::t_elapsed        w_e_inc   [mclb_pkg::CHANNELS];
    mclb_pkg::t_time           w_rep_dec [mclb_pkg::CHANNELS];

    // output stage
    logic            r_out_valid;
    mclb_pkg::t_rsp  r_out;
    mclb_pkg::t_rsp  n_out;

    // handshake: stage 1 moves on when stage 2 is free or being drained
    assign w_adv       = r_in_valid && (!r_out_valid || i_rsp_ready);
    assign o_req_ready = !r_in_valid || w_adv;
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_req_ready) begin
                r_in_valid <= i_req_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_in <= i_req;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // saturating increment and repeat decrement per channel
    always_comb begin
        for (int c = 0; c < mclb_pkg::CHANNELS; c++) begin
            w_e_inc[c]   = (r_elapsed[c] == '1) ? r_elapsed[c]
                                                : r_elapsed[c] + mclb_pkg::ELAPSED_BITS'(1);
            w_rep_dec[c] = r_rep[c] - mclb_pkg::TIME_BITS'(1);
        end
    end

    // next channel state
    always_comb begin
        for (int c = 0; c < mclb_pkg::CHANNELS; c++) begin
            n_level[c]   = r_level[c];
            n_lit[c]     = r_lit[c];
            n_cycle[c]   = r_cycle[c];
            n_rep[c]     = r_rep[c];
            n_elapsed[c] = r_elapsed[c];
            if (r_in.command == mclb_pkg::CMD_TICK) begin
                if (r_cycle[c] != '0) begin
                    n_elapsed[c] = w_e_inc[c];
                    if (w_e_inc[c] > mclb_pkg::ELAPSED_BITS'(r_cycle[c])) begin
                        // end of a blink cycle
                        if (r_rep[c] != '0) begin
                            n_rep[c] = w_rep_dec[c];
                        end
                        if (r_rep[c] == mclb_pkg::TIME_BITS'(1)) begin
                            n_cycle[c] = '0;
                        end else begin
                            n_level[c]   = 1'b1;
                            n_elapsed[c] = '0;
                        end
                    end else if (w_e_inc[c] > mclb_pkg::ELAPSED_BITS'(r_lit[c])) begin
                        n_level[c] = 1'b0;
                    end
                end
            end else if (int'(r_in.channel) == c) begin
                case (r_in.command)
                    mclb_pkg::CMD_OFF: n_level[c] = 1'b0;
                    mclb_pkg::CMD_ON:  n_level[c] = 1'b1;
                    mclb_pkg::CMD_TOG: n_level[c] = !r_level[c];
                    mclb_pkg::CMD_BLINK: begin
                        n_level[c]   = 1'b1;
                        n_lit[c]     = mclb_pkg::TIME_BITS'(r_in.on_time);
                        n_cycle[c]   = mclb_pkg::TIME_BITS'(r_in.blink_period);
                        n_rep[c]     = mclb_pkg::TIME_BITS'(r_in.repeat_count);
                        n_elapsed[c] = '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // response from the updated state
    always_comb begin
        n_out = '0;
        for (int c = 0; c < mclb_pkg::OUT_CH; c++) begin
            n_out.led_levels[c]   = n_level[c];
            n_out.blink_active[c] = (n_cycle[c] != '0);
        end
    end

    // channel state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < mclb_pkg::CHANNELS; c++) begin
                r_level[c]   <= 1'b0;
                r_lit[c]     <= '0;
                r_cycle[c]   <= '0;
                r_rep[c]     <= '0;
                r_elapsed[c] <= '0;
            end
        end else if (w_adv) begin
            for (int c = 0; c < mclb_pkg::CHANNELS; c++) begin
                r_level[c]   <= n_level[c];
                r_lit[c]     <= n_lit[c];
                r_cycle[c]   <= n_cycle[c];
                r_rep[c]     <= n_rep[c];
                r_elapsed[c] <= n_elapsed[c];
            end
        end
    end

    // checks
    `MCLB_ASSERT_NEXT(a_fill_out, i_clk, i_rst_n, r_in_valid && !r_out_valid, r_out_valid)
    `MCLB_ASSERT_NEXT(a_hold_state, i_clk, i_rst_n, !w_adv, $stable(r_cycle[0]) && $stable(r_level[0]))
    `MCLB_ASSERT(a_rsp_matches, i_clk, i_rst_n,
        o_rsp_valid |-> (o_rsp.blink_active[0] == (r_cycle[0] != '0)))

    for (genvar g = 0; g < mclb_pkg::CHANNELS; g++) begin : g_chk
        `MCLB_ASSERT(a_elapsed_bound, i_clk, i_rst_n,
            (r_cycle[g] != '0) |-> (r_elapsed[g] <= mclb_pkg::ELAPSED_BITS'(r_cycle[g])))
    end

endmodule

`default_nettype wire
